[hdl/ltgd_pkg.sv]
// shared types and constants of the linear trend growth detector
`timescale 1ns / 1ps
`default_nettype none

package ltgd_pkg;

   // default sizing of the series
   localparam int MAX_SAMPLES_DEF = 256;
   localparam int SAMPLE_BITS_DEF = 24;

   // field widths fixed by the interface
   localparam int FIELD_W   = 24;
   localparam int THRESH_W  = 23;
   localparam int SLOPE_W   = 24;
   localparam int STATUS_W  = 2;
   localparam int FRAC_BITS = 16;

   // threshold after reset, 0.1 in Q16
   localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd6554;

   // saturation limits of the slope magnitude
   localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 24'h7FFFFF;
   localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = 24'h800000;

   // width of the serial multiplier bit counter
   localparam int CYC_W = 6;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_EVALUATED  = 2'd0,
      STATUS_DEGENERATE = 2'd1,
      STATUS_OVERFLOW   = 2'd2
   } status_type;

   // control of the serial multiply-accumulate unit
   typedef struct packed {
      logic             start;
      logic             sub;
      logic [CYC_W-1:0] nbits;
   } mac_ctrl_type;

   // status of the serial divider
   typedef struct packed {
      logic done;
      logic ovf;
      logic rem_nz;
   } div_stat_type;

endpackage

`default_nettype wire

[hdl/ltgd_mac.sv]
// bit-serial multiply-accumulate unit: acc = init +/- a * b, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ltgd_mac #(
   parameter int A_W   = 64,
   parameter int B_W   = 32,
   parameter int ACC_W = 88
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ltgd_pkg::mac_ctrl_type ctrl,
   input  wire logic [A_W-1:0]        a,
   input  wire logic [B_W-1:0]        b,
   input  wire logic [ACC_W-1:0]      init,
   output logic                       done,
   output logic [ACC_W-1:0]           acc
);

   localparam int CW = ltgd_pkg::CYC_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sub_ff, sub_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0] a_sh_ff, a_sh_in;
   logic [B_W-1:0]   b_sh_ff, b_sh_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] addend;
   logic [ACC_W-1:0] sum;

   // add or subtract the shifted multiplicand
   assign addend = sub_ff ? ~a_sh_ff : a_sh_ff;
   assign sum    = acc_ff + addend + ACC_W'(sub_ff);

   // next state of the shift-and-add loop
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sub_in  = sub_ff;
      cnt_in  = cnt_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         sub_in  = ctrl.sub;
         cnt_in  = ctrl.nbits;
         a_sh_in = ACC_W'(a);
         b_sh_in = b;
         acc_in  = init;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_in = sum;
         end
         a_sh_in = a_sh_ff << 1;
         b_sh_in = b_sh_ff >> 1;
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sub_ff  <= sub_in;
      cnt_ff  <= cnt_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

[hdl/ltgd_div.sv]
// restoring divider, one quotient bit per cycle, with overflow check of the top bit
`timescale 1ns / 1ps
`default_nettype none

module ltgd_div #(
   parameter int DIV_W = 112,
   parameter int Q_W   = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DIV_W-1:0]       dividend,
   input  wire logic [DIV_W-1:0]       divisor,
   output ltgd_pkg::div_stat_type      stat,
   output logic [Q_W-1:0]              quotient
);

   localparam int SW = $clog2(Q_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [DIV_W:0]   diff;
   logic             ge;
   logic             first;

   // trial subtraction of the shifted divisor
   assign diff  = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign ge    = ~diff[DIV_W];
   assign first = (step_ff == SW'(Q_W));

   // next state of the division loop
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         ovf_in  = 1'b0;
         step_in = SW'(Q_W);
         rem_in  = dividend;
         dsh_in  = divisor << Q_W;
         q_in    = '0;
      end else if (busy_ff) begin
         if (first && ge) begin
            // quotient does not fit, stop early
            ovf_in  = 1'b1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (ge) begin
               rem_in = diff[DIV_W-1:0];
            end
            if (!first) begin
               q_in = {q_ff[Q_W-2:0], ge};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - SW'(1);
            if (step_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ovf_ff  <= ovf_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

   assign stat.done   = done_ff;
   assign stat.ovf    = ovf_ff;
   assign stat.rem_nz = |rem_ff;
   assign quotient    = q_ff;

endmodule

`default_nettype wire

[hdl/linear_trend_growth_detector_core.sv]
// Top level of the linear trend growth detector: series accumulation and slope evaluation.
// A sample is processed by the bit-serial multiplier, which forms t*t and t*m one multiplier
// bit per cycle; a sample is taken only in the idle state.
// The last sample of a series with spread on both axes adds four more serial products,
// two scaling products and a 25-step restoring division.
// Synchronous active-high reset: threshold to 0.1 in Q16, series cleared, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module linear_trend_growth_detector_core #(
   parameter int MAX_SAMPLES = ltgd_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = ltgd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // sample channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ltgd_pkg::FIELD_W-1:0]  req_sample_time,
   input  wire logic [ltgd_pkg::FIELD_W-1:0]  req_memory_used,
   input  wire logic                          req_last_sample,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_growing,
   output logic signed [ltgd_pkg::SLOPE_W-1:0] rsp_slope_q16,
   output logic [ltgd_pkg::STATUS_W-1:0]      rsp_status,
   // threshold register
   input  wire logic                          csr_write_enable,
   input  wire logic [ltgd_pkg::THRESH_W-1:0] csr_write_data
);

   localparam int SB     = SAMPLE_BITS;
   localparam int LG     = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 2);
   localparam int SUM_W  = SB + LG;
   localparam int SQ_W   = 2 * SB + LG;
   localparam int NUM_W  = 2 * SB + 2 * LG;
   localparam int PROD_W = NUM_W + SB;
   localparam int SL_W   = ltgd_pkg::SLOPE_W;
   localparam int DIV_W  = PROD_W + SL_W;
   localparam int TH_W   = ltgd_pkg::THRESH_W;
   localparam int ST_W   = ltgd_pkg::STATUS_W;
   localparam int CW     = ltgd_pkg::CYC_W;
   localparam int FRAC   = ltgd_pkg::FRAC_BITS;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_ISSUE    = 6'b000010,
      S_WAIT     = 6'b000100,
      S_DIV_GO   = 6'b001000,
      S_DIV_WAIT = 6'b010000,
      S_DONE     = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      OP_SQUARE,
      OP_CROSS,
      OP_N_SXY,
      OP_SX_SY,
      OP_N_SXX,
      OP_SX_SX,
      OP_TOP,
      OP_BOT
   } op_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic                 last_ff, last_in;
   ltgd_pkg::status_type status_ff, status_in;
   logic [TH_W-1:0]      thr_ff, thr_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SB-1:0]        lo_t_ff, lo_t_in, hi_t_ff, hi_t_in;
   logic [SB-1:0]        lo_m_ff, lo_m_in, hi_m_ff, hi_m_in;
   logic [SUM_W-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic [SQ_W-1:0]      sxx_ff, sxx_in, sxy_ff, sxy_in;
   logic [SB-1:0]        t_ff, t_in, m_ff, m_in;

   logic                 neg_ff, neg_in;
   logic [NUM_W-1:0]     mag_ff, mag_in;
   logic [NUM_W-1:0]     den_ff, den_in;
   logic [PROD_W-1:0]    top_ff, top_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_growing_ff, rsp_growing_in;
   logic [SL_W-1:0]      rsp_slope_ff, rsp_slope_in;
   logic [ST_W-1:0]      rsp_status_ff, rsp_status_in;

   ltgd_pkg::mac_ctrl_type mac_ctrl;
   logic [NUM_W-1:0]     mac_a;
   logic [SUM_W-1:0]     mac_b;
   logic [PROD_W-1:0]    mac_init;
   logic                 mac_done;
   logic [PROD_W-1:0]    mac_acc;

   ltgd_pkg::div_stat_type div_stat;
   logic [SL_W-1:0]      quot;

   logic [SB-1:0]        t_new, m_new;
   logic                 take;
   logic                 out_free;
   logic [NUM_W-1:0]     num;
   logic [SL_W-1:0]      cap, sat, slope_val, thr_ext;
   logic                 grow_val;

   // sample fields narrowed to the used bits
   assign t_new    = req_sample_time[SB-1:0];
   assign m_new    = req_memory_used[SB-1:0];
   assign take     = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign num      = mac_acc[NUM_W-1:0];

   // operand selection for the serial multiplier
   always_comb begin
      mac_ctrl.start = (state_ff == S_ISSUE);
      mac_ctrl.sub   = 1'b0;
      mac_ctrl.nbits = CW'(SB);
      mac_a          = NUM_W'(t_ff);
      mac_b          = SUM_W'(t_ff);
      mac_init       = '0;
      unique case (op_ff)
         OP_SQUARE: begin
            mac_init = PROD_W'(sxx_ff);
         end
         OP_CROSS: begin
            mac_a    = NUM_W'(m_ff);
            mac_init = PROD_W'(sxy_ff);
         end
         OP_N_SXY: begin
            mac_a          = NUM_W'(sxy_ff);
            mac_b          = SUM_W'(count_ff);
            mac_ctrl.nbits = CW'(CNT_W);
         end
         OP_SX_SY: begin
            mac_a          = NUM_W'(sx_ff);
            mac_b          = sy_ff;
            mac_init       = mac_acc;
            mac_ctrl.sub   = 1'b1;
            mac_ctrl.nbits = CW'(SUM_W);
         end
         OP_N_SXX: begin
            mac_a          = NUM_W'(sxx_ff);
            mac_b          = SUM_W'(count_ff);
            mac_ctrl.nbits = CW'(CNT_W);
         end
         OP_SX_SX: begin
            mac_a          = NUM_W'(sx_ff);
            mac_b          = sx_ff;
            mac_init       = mac_acc;
            mac_ctrl.sub   = 1'b1;
            mac_ctrl.nbits = CW'(SUM_W);
         end
         OP_TOP: begin
            mac_a = mag_ff;
            mac_b = SUM_W'(hi_t_ff - lo_t_ff);
         end
         OP_BOT: begin
            mac_a = den_ff;
            mac_b = SUM_W'(hi_m_ff - lo_m_ff);
         end
      endcase
   end

   ltgd_mac #(
      .A_W   (NUM_W),
      .B_W   (SUM_W),
      .ACC_W (PROD_W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .a     (mac_a),
      .b     (mac_b),
      .init  (mac_init),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   ltgd_div #(
      .DIV_W (DIV_W),
      .Q_W   (SL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .dividend (DIV_W'({top_ff, {FRAC{1'b0}}})),
      .divisor  (DIV_W'(mac_acc)),
      .stat     (div_stat),
      .quotient (quot)
   );

   // saturation and threshold compare of the quotient
   always_comb begin
      thr_ext   = SL_W'(thr_ff);
      cap       = neg_ff ? ltgd_pkg::SLOPE_NEG_MAX : ltgd_pkg::SLOPE_POS_MAX;
      sat       = (div_stat.ovf || (quot > cap)) ? cap : quot;
      slope_val = neg_ff ? (SL_W'(0) - sat) : sat;
      grow_val  = !neg_ff && (div_stat.ovf || (quot > thr_ext) ||
                              ((quot == thr_ext) && div_stat.rem_nz));
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      last_in        = last_ff;
      status_in      = status_ff;
      thr_in         = csr_write_enable ? csr_write_data : thr_ff;
      count_in       = count_ff;
      lo_t_in        = lo_t_ff;
      hi_t_in        = hi_t_ff;
      lo_m_in        = lo_m_ff;
      hi_m_in        = hi_m_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      sxx_in         = sxx_ff;
      sxy_in         = sxy_ff;
      t_in           = t_ff;
      m_in           = m_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      den_in         = den_ff;
      top_in         = top_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_growing_in = rsp_growing_ff;
      rsp_slope_in   = rsp_slope_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               last_in = req_last_sample;
               if (count_ff >= CNT_W'(MAX_SAMPLES)) begin
                  // series too long, mark and drop the sample
                  count_in = CNT_W'(MAX_SAMPLES + 1);
                  if (req_last_sample) begin
                     status_in = ltgd_pkg::STATUS_OVERFLOW;
                     state_in  = S_DONE;
                  end
               end else begin
                  t_in = t_new;
                  m_in = m_new;
                  if (count_ff == '0) begin
                     lo_t_in = t_new;
                     hi_t_in = t_new;
                     lo_m_in = m_new;
                     hi_m_in = m_new;
                  end else begin
                     if (t_new < lo_t_ff) lo_t_in = t_new;
                     if (t_new > hi_t_ff) hi_t_in = t_new;
                     if (m_new < lo_m_ff) lo_m_in = m_new;
                     if (m_new > hi_m_ff) hi_m_in = m_new;
                  end
                  count_in = count_ff + CNT_W'(1);
                  sx_in    = sx_ff + SUM_W'(t_new);
                  sy_in    = sy_ff + SUM_W'(m_new);
                  op_in    = OP_SQUARE;
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (mac_done) begin
               state_in = S_ISSUE;
               unique case (op_ff)
                  OP_SQUARE: begin
                     sxx_in = mac_acc[SQ_W-1:0];
                     op_in  = OP_CROSS;
                  end
                  OP_CROSS: begin
                     sxy_in = mac_acc[SQ_W-1:0];
                     if (!last_ff) begin
                        state_in = S_IDLE;
                     end else if ((lo_t_ff == hi_t_ff) || (lo_m_ff == hi_m_ff)) begin
                        status_in = ltgd_pkg::STATUS_DEGENERATE;
                        state_in  = S_DONE;
                     end else begin
                        status_in = ltgd_pkg::STATUS_EVALUATED;
                        op_in     = OP_N_SXY;
                     end
                  end
                  OP_N_SXY: begin
                     op_in = OP_SX_SY;
                  end
                  OP_SX_SY: begin
                     neg_in = num[NUM_W-1];
                     mag_in = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
                     op_in  = OP_N_SXX;
                  end
                  OP_N_SXX: begin
                     op_in = OP_SX_SX;
                  end
                  OP_SX_SX: begin
                     den_in = num;
                     op_in  = OP_TOP;
                  end
                  OP_TOP: begin
                     top_in = mac_acc;
                     op_in  = OP_BOT;
                  end
                  OP_BOT: begin
                     state_in = S_DIV_GO;
                  end
               endcase
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               // hand the result to the output register and clear the series
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == ltgd_pkg::STATUS_EVALUATED) begin
                  rsp_growing_in = grow_val;
                  rsp_slope_in   = slope_val;
               end else begin
                  rsp_growing_in = 1'b0;
                  rsp_slope_in   = '0;
               end
               count_in = '0;
               sx_in    = '0;
               sy_in    = '0;
               sxx_in   = '0;
               sxy_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and series registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= ltgd_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      last_ff        <= last_in;
      status_ff      <= status_in;
      lo_t_ff        <= lo_t_in;
      hi_t_ff        <= hi_t_in;
      lo_m_ff        <= lo_m_in;
      hi_m_ff        <= hi_m_in;
      t_ff           <= t_in;
      m_ff           <= m_in;
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      den_ff         <= den_in;
      top_ff         <= top_in;
      rsp_growing_ff <= rsp_growing_in;
      rsp_slope_ff   <= rsp_slope_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_growing   = rsp_growing_ff;
   assign rsp_slope_q16 = $signed(rsp_slope_ff);
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

[dv/linear_trend_growth_detector_core_test.sv]
// self-checking testbench of the linear trend growth detector core
`timescale 1ns / 1ps
`default_nettype none

module linear_trend_growth_detector_core_test;

   localparam int FIELD_W     = ltgd_pkg::FIELD_W;
   localparam int THRESH_W    = ltgd_pkg::THRESH_W;
   localparam int SLOPE_W     = ltgd_pkg::SLOPE_W;
   localparam int STATUS_W    = ltgd_pkg::STATUS_W;
   localparam int MAX_SAMPLES = ltgd_pkg::MAX_SAMPLES_DEF;

   // one sample, and the extra work of the slope fit on the last one
   localparam int SAMPLE_CYCLES  = 2 * ltgd_pkg::SAMPLE_BITS_DEF + 5;
   localparam int FIT_CYCLES     = 4 * ltgd_pkg::SAMPLE_BITS_DEF + 4 * 8 + 42;
   localparam int SETTLE_CYCLES  = SAMPLE_CYCLES + FIT_CYCLES;
   localparam int WATCHDOG_LIMIT = 10 * (SETTLE_CYCLES + 2 * 9);
   localparam int RANDOM_ITEMS   = 150;
   localparam logic [FIELD_W-1:0]  FIELD_MAX  = '1;
   localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

   typedef struct packed {
      logic [FIELD_W-1:0] sample_time;
      logic [FIELD_W-1:0] memory_used;
      logic               last_sample;
   } sample_type;

   typedef struct packed {
      logic                 growing;
      logic [SLOPE_W-1:0]   slope_q16;
      ltgd_pkg::status_type status;
   } trend_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   wire                        req_stall;
   logic [FIELD_W-1:0]         req_sample_time = '0;
   logic [FIELD_W-1:0]         req_memory_used = '0;
   logic                       req_last_sample = 1'b0;
   wire                        rsp_valid;
   logic                       rsp_stall = 1'b0;
   wire                        rsp_growing;
   wire signed [SLOPE_W-1:0]   rsp_slope_q16;
   wire [STATUS_W-1:0]         rsp_status;
   logic                       csr_write_enable = 1'b0;
   logic [THRESH_W-1:0]        csr_write_data = '0;

   linear_trend_growth_detector_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_time  (req_sample_time),
      .req_memory_used  (req_memory_used),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_growing      (rsp_growing),
      .rsp_slope_q16    (rsp_slope_q16),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // series state and threshold as the block should hold them
   logic [THRESH_W-1:0] growth_limit = ltgd_pkg::THRESH_RESET;
   int unsigned         series_count = 0;
   logic [FIELD_W-1:0]  time_low = '0, time_high = '0, mem_low = '0, mem_high = '0;
   logic [63:0]         time_sum = '0, mem_sum = '0, time_sq_sum = '0, cross_sum = '0;

   sample_type  sample_backlog[$];
   trend_type   expected_trends[$];
   int unsigned samples_queued = 0;
   int unsigned samples_taken = 0;
   int          mismatch_count = 0;

   // fold one accepted sample into the series; on the last one fit the slope
   task automatic fit_trend(input sample_type s);
      logic [63:0]        num, den, mag;
      logic [127:0]       top, bot, quo, rem;
      logic               neg;
      logic [SLOPE_W-1:0] sat, cap;
      trend_type          r;
      if (series_count >= MAX_SAMPLES) begin
         series_count = MAX_SAMPLES + 1;
      end else begin
         if (series_count == 0) begin
            time_low  = s.sample_time;
            time_high = s.sample_time;
            mem_low   = s.memory_used;
            mem_high  = s.memory_used;
         end else begin
            if (s.sample_time < time_low) time_low = s.sample_time;
            if (s.sample_time > time_high) time_high = s.sample_time;
            if (s.memory_used < mem_low) mem_low = s.memory_used;
            if (s.memory_used > mem_high) mem_high = s.memory_used;
         end
         series_count++;
         time_sum    += 64'(s.sample_time);
         mem_sum     += 64'(s.memory_used);
         time_sq_sum += 64'(s.sample_time) * 64'(s.sample_time);
         cross_sum   += 64'(s.sample_time) * 64'(s.memory_used);
      end
      if (s.last_sample) begin
         r.growing   = 1'b0;
         r.slope_q16 = '0;
         r.status    = ltgd_pkg::STATUS_EVALUATED;
         if (series_count > MAX_SAMPLES) begin
            r.status = ltgd_pkg::STATUS_OVERFLOW;
         end else if (time_low == time_high || mem_low == mem_high) begin
            r.status = ltgd_pkg::STATUS_DEGENERATE;
         end else begin
            // raw slope scaled by time range over memory range, exact division
            num = 64'(series_count) * cross_sum - time_sum * mem_sum;
            den = 64'(series_count) * time_sq_sum - time_sum * time_sum;
            neg = num[63];
            mag = neg ? -num : num;
            top = (128'(mag) * 128'(time_high - time_low)) << ltgd_pkg::FRAC_BITS;
            bot = 128'(den) * 128'(mem_high - mem_low);
            quo = top / bot;
            rem = top % bot;
            cap = neg ? ltgd_pkg::SLOPE_NEG_MAX : ltgd_pkg::SLOPE_POS_MAX;
            sat = (quo > 128'(cap)) ? cap : quo[SLOPE_W-1:0];
            r.slope_q16 = neg ? -sat : sat;
            r.growing = !neg && (quo > 128'(growth_limit) ||
                                 (quo == 128'(growth_limit) && rem != 0));
         end
         expected_trends.push_back(r);
         series_count = 0;
         time_low = '0; time_high = '0; mem_low = '0; mem_high = '0;
         time_sum = '0; mem_sum = '0; time_sq_sum = '0; cross_sum = '0;
      end
   endtask

   // sample driver: gap before each transfer, held while stalled
   int unsigned req_gap = 0;
   bit          req_burst = 1'b0;

   always @(posedge clock) begin : sample_driver
      sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            fit_trend({req_sample_time, req_memory_used, req_last_sample});
            samples_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               next_sample = sample_backlog.pop_front();
               req_sample_time <= next_sample.sample_time;
               req_memory_used <= next_sample.memory_used;
               req_last_sample <= next_sample.last_sample;
               req_valid <= 1'b1;
               if ($urandom_range(0, 15) == 0) req_burst = !req_burst;
               req_gap = req_burst ? 0 : $urandom_range(0, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks each result, then stalls the result channel for a random hold
   int unsigned rsp_hold = 0;
   bit          rsp_burst = 1'b0;

   always @(posedge clock) begin : result_monitor
      trend_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_trends.size() == 0) begin
            $error("unexpected result: growing %0d slope_q16 %0d status %0d",
                   rsp_growing, rsp_slope_q16, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_trends.pop_front();
            if (rsp_growing !== want.growing) begin
               $error("growing: expected %0d, got %0d", want.growing, rsp_growing);
               mismatch_count++;
            end
            if (rsp_slope_q16 !== want.slope_q16) begin
               $error("slope_q16: expected %0d, got %0d", $signed(want.slope_q16),
                      rsp_slope_q16);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
         if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
         rsp_hold = rsp_burst ? 0 : $urandom_range(0, 8);
         rsp_stall <= (rsp_hold != 0);
      end else if (rsp_valid && rsp_hold != 0) begin
         rsp_hold--;
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // watchdog on cycles without any transfer
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_sample(input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] m,
                              input logic last);
      sample_type s;
      s.sample_time = t;
      s.memory_used = m;
      s.last_sample = last;
      sample_backlog.push_back(s);
      samples_queued++;
   endtask

   function automatic logic [FIELD_W-1:0] rand_field();
      case ($urandom_range(0, 3))
         0:       return FIELD_W'($urandom_range(0, 3));
         1:       return FIELD_MAX - FIELD_W'($urandom_range(0, 3));
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   // style 0 noise, 1 rising or falling trend with jitter, 2 tiny values
   task automatic queue_series(input int unsigned len, input int unsigned style);
      logic [FIELD_W-1:0] t, m, t_step, m_step;
      logic               m_down;
      t = rand_field();
      m = rand_field();
      t_step = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom)
                                           : FIELD_W'($urandom_range(1, 4096));
      m_step = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom)
                                           : FIELD_W'($urandom_range(0, 4096));
      m_down = 1'($urandom_range(0, 1));
      for (int unsigned i = 0; i < len; i++) begin
         case (style)
            0: push_sample(rand_field(), rand_field(), i == len - 1);
            1: begin
               push_sample(t, m + FIELD_W'($urandom_range(0, 15)), i == len - 1);
               t = t + t_step;
               m = m_down ? m - m_step : m + m_step;
            end
            default: push_sample(FIELD_W'($urandom_range(0, 3)),
                                 FIELD_W'($urandom_range(0, 3)), i == len - 1);
         endcase
      end
   endtask

   // wait for every transfer and result, then let the block settle
   task automatic drain();
      do @(negedge clock);
      while (samples_taken != samples_queued || expected_trends.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      growth_limit = value;
   endtask

   initial begin : stimulus
      int unsigned         random_start;
      int unsigned         style;
      logic [THRESH_W-1:0] level;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-sample series at both extremes are degenerate
      push_sample('0, '0, 1'b1);
      push_sample(FIELD_MAX, FIELD_MAX, 1'b1);
      // constant time, then constant memory
      push_sample(24'd5, 24'd1, 1'b0);
      push_sample(24'd5, 24'd9, 1'b1);
      push_sample(24'd1, 24'd7, 1'b0);
      push_sample(24'd9, 24'd7, 1'b1);
      // full-range rise and fall
      push_sample('0, '0, 1'b0);
      push_sample(FIELD_MAX, FIELD_MAX, 1'b1);
      push_sample('0, FIELD_MAX, 1'b0);
      push_sample(FIELD_MAX, '0, 1'b1);
      // zero slope with both axes spread
      push_sample(24'd0, 24'd0, 1'b0);
      push_sample(24'd1, 24'd5, 1'b0);
      push_sample(24'd2, 24'd0, 1'b1);
      drain();

      // a slope of exactly one ties with the threshold and is not growing
      write_threshold(THRESH_W'(65536));
      push_sample(24'd0, 24'd0, 1'b0);
      push_sample(24'd100, 24'd100, 1'b1);
      push_sample(24'd3, 24'd40, 1'b0);
      push_sample(24'd8, 24'd2, 1'b1);
      drain();

      // zero threshold: flat trend ties, small rise grows
      write_threshold('0);
      push_sample(24'd0, 24'd0, 1'b0);
      push_sample(24'd1, 24'd5, 1'b0);
      push_sample(24'd2, 24'd0, 1'b1);
      push_sample(24'd0, 24'd0, 1'b0);
      push_sample(24'd1, 24'd0, 1'b0);
      push_sample(24'd2, 24'd1, 1'b0);
      push_sample(24'd3, 24'd0, 1'b1);
      drain();

      write_threshold(THRESH_MAX);
      push_sample('0, '0, 1'b0);
      push_sample(FIELD_MAX, FIELD_MAX, 1'b1);
      drain();

      // random phases, each under its own threshold
      random_start = samples_queued;
      while (samples_queued < random_start + RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       level = THRESH_W'($urandom);
            1:       level = THRESH_W'($urandom_range(0, 131072));
            2:       level = '0;
            default: level = THRESH_MAX;
         endcase
         write_threshold(level);
         repeat ($urandom_range(4, 10)) begin
            style = $urandom_range(0, 9);
            queue_series(($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8),
                         (style < 5) ? 1 : (style < 8) ? 0 : 2);
         end
         drain();
      end

      // series one past the sample limit, then a fresh one
      write_threshold(THRESH_W'($urandom_range(0, 131072)));
      queue_series(MAX_SAMPLES + 1, 0);
      queue_series(3, 1);
      drain();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/ltgd_pkg.sv
hdl/ltgd_mac.sv
hdl/ltgd_div.sv
hdl/linear_trend_growth_detector_core.sv
dv/linear_trend_growth_detector_core_test.sv
